FILE: rtl/core/mkq_pkg.sv
// Shared types and constants for the 3-D Morton key quantizer.
package mkq_pkg;

    localparam int COORD_W = 32;
    localparam int KEY_W   = 63;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_LEN  = 2'd3;

    // Per-stage load strobes shared by the three lanes
    typedef struct packed {
        logic ld_diff;
        logic ld_prod;
        logic ld_code;
    } t_lane_ctl;

endpackage

FILE: rtl/core/morton_key_3d_quantize_top.sv
// Top level: 3-D Morton key quantizer with three axis lanes and a merge stage.
// Pipeline: four register stages (diff, multiply, quantize, merge); o_m_tvalid rises once an item
// reaches the merge register, and the output transfer then waits for i_m_tready.
// Throughput: one transfer per cycle while i_m_tready stays high.
// Stages advance independently, so bubbles collapse and input is taken while a key waits.
// Reset (i_rst_n low at a clock edge) clears all stage valids and the four config registers.
module morton_key_3d_quantize_top
    import mkq_pkg::*;
#(
    parameter int AXIS_BITS = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [3*COORD_W-1:0] i_s_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    input  logic                 i_s_tlast,   // last_in
    // output stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [KEY_W:0]       o_m_tdata,   // morton_key [62:0], zero pad [63]
    output logic                 o_m_tlast    // last_out
);

    // config registers
    logic signed [COORD_W-1:0] r_corner_x;
    logic signed [COORD_W-1:0] r_corner_y;
    logic signed [COORD_W-1:0] r_corner_z;
    logic [COORD_W-1:0]        r_scale;

    // stage valids: diff, product, code, output
    logic r_v0, r_v1, r_v2, r_v3;
    logic r_last0, r_last1, r_last2;
    logic w_acc, w_mv0, w_mv1, w_mv2, w_mv3;

    t_lane_ctl w_ctl;

    logic [AXIS_BITS-1:0] w_code_x, w_code_y, w_code_z;
    logic [KEY_W-1:0]     w_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_x <= '0;
            r_corner_y <= '0;
            r_corner_z <= '0;
            r_scale    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CORNER_X: r_corner_x <= i_cfg_wdata;
                CFG_CORNER_Y: r_corner_y <= i_cfg_wdata;
                CFG_CORNER_Z: r_corner_z <= i_cfg_wdata;
                CFG_INV_LEN:  r_scale    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage moves forward when it holds data and the next one is empty or moving
    assign w_mv3 = r_v3 & i_m_tready;
    assign w_mv2 = r_v2 & (~r_v3 | w_mv3);
    assign w_mv1 = r_v1 & (~r_v2 | w_mv2);
    assign w_mv0 = r_v0 & (~r_v1 | w_mv1);
    assign o_s_tready = ~r_v0 | w_mv0;
    assign w_acc = i_s_tvalid & o_s_tready;

    assign w_ctl.ld_diff = w_acc;
    assign w_ctl.ld_prod = w_mv0;
    assign w_ctl.ld_code = w_mv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= w_acc | (r_v0 & ~w_mv0);
            r_v1 <= w_mv0 | (r_v1 & ~w_mv1);
            r_v2 <= w_mv1 | (r_v2 & ~w_mv2);
            r_v3 <= w_mv2 | (r_v3 & ~w_mv3);
        end
    end

    // tlast rides alongside the lane payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_last0 <= i_s_tlast;
        end
        if (w_mv0) begin
            r_last1 <= r_last0;
        end
        if (w_mv1) begin
            r_last2 <= r_last1;
        end
    end

    mkq_lane #(.AXIS_BITS(AXIS_BITS)) u_lane_x (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_pos    (i_s_tdata[COORD_W-1:0]),
        .i_corner (r_corner_x),
        .i_scale  (r_scale),
        .o_code   (w_code_x)
    );

    mkq_lane #(.AXIS_BITS(AXIS_BITS)) u_lane_y (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_pos    (i_s_tdata[2*COORD_W-1:COORD_W]),
        .i_corner (r_corner_y),
        .i_scale  (r_scale),
        .o_code   (w_code_y)
    );

    mkq_lane #(.AXIS_BITS(AXIS_BITS)) u_lane_z (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_pos    (i_s_tdata[3*COORD_W-1:2*COORD_W]),
        .i_corner (r_corner_z),
        .i_scale  (r_scale),
        .o_code   (w_code_z)
    );

    mkq_merge #(.AXIS_BITS(AXIS_BITS)) u_merge (
        .i_clk    (i_clk),
        .i_ld     (w_mv2),
        .i_code_x (w_code_x),
        .i_code_y (w_code_y),
        .i_code_z (w_code_z),
        .i_last   (r_last2),
        .o_key    (w_key),
        .o_last   (o_m_tlast)
    );

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {1'b0, w_key};

`ifndef SYNTHESIS
    // a transfer always lands in the first stage
    a_acc_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_v0)
        else $error("accepted item not captured in diff stage");

    // backpressure only when the front stage is occupied
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_v0)
        else $error("input stalled with empty front stage");

    // a quantized code that moves on always reaches the output register
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && (!r_v3 || i_m_tready)) |=> r_v3)
        else $error("quantized code lost before output register");
`endif

endmodule

FILE: rtl/core/mkq_lane.sv
// One axis lane: corner subtract, scale multiply, clamp and quantize.
module mkq_lane
    import mkq_pkg::*;
#(
    parameter int AXIS_BITS = 21
) (
    input  logic                     i_clk,
    input  t_lane_ctl                i_ctl,
    input  logic signed [COORD_W-1:0] i_pos,
    input  logic signed [COORD_W-1:0] i_corner,
    input  logic [COORD_W-1:0]       i_scale,
    output logic [AXIS_BITS-1:0]     o_code
);

    localparam int PROD_W = 2 * COORD_W;
    localparam int FRAC_W = COORD_W + AXIS_BITS;

    logic signed [COORD_W:0] w_diff;
    logic [COORD_W-1:0]      r_mag;
    logic [PROD_W-1:0]       r_prod;
    logic [FRAC_W-1:0]       w_scaled;
    logic [AXIS_BITS-1:0]    r_code;
    logic [AXIS_BITS-1:0]    n_code;

    // exact 33-bit difference; non-positive values quantize to zero
    assign w_diff = {i_pos[COORD_W-1], i_pos} - {i_corner[COORD_W-1], i_corner};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_diff) begin
            r_mag <= w_diff[COORD_W] ? '0 : w_diff[COORD_W-1:0];
        end
        if (i_ctl.ld_prod) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(i_scale);
        end
        if (i_ctl.ld_code) begin
            r_code <= n_code;
        end
    end

    // frac * (2^A - 1) as shift and subtract
    assign w_scaled = {r_prod[COORD_W-1:0], {AXIS_BITS{1'b0}}}
                    - FRAC_W'(r_prod[COORD_W-1:0]);

    always_comb begin
        if (r_prod[PROD_W-1:COORD_W] != '0) begin
            n_code = '1;
        end else begin
            n_code = w_scaled[FRAC_W-1:COORD_W];
        end
    end

    assign o_code = r_code;

endmodule

FILE: rtl/core/mkq_merge.sv
// Merge stage: interleaves the three axis codes into the output key register.
module mkq_merge
    import mkq_pkg::*;
#(
    parameter int AXIS_BITS = 21
) (
    input  logic                 i_clk,
    input  logic                 i_ld,
    input  logic [AXIS_BITS-1:0] i_code_x,
    input  logic [AXIS_BITS-1:0] i_code_y,
    input  logic [AXIS_BITS-1:0] i_code_z,
    input  logic                 i_last,
    output logic [KEY_W-1:0]     o_key,
    output logic                 o_last
);

    logic [KEY_W-1:0] n_key;
    logic [KEY_W-1:0] r_key;
    logic             r_last;

    always_comb begin
        n_key = '0;
        for (int k = 0; k < AXIS_BITS; k++) begin
            n_key[3*k]     = i_code_x[k];
            n_key[3*k + 1] = i_code_y[k];
            n_key[3*k + 2] = i_code_z[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_key  <= n_key;
            r_last <= i_last;
        end
    end

    assign o_key  = r_key;
    assign o_last = r_last;

endmodule

FILE: sim/morton_key_3d_quantize_top_tb.sv
// Self-checking testbench for the 3-D Morton key quantizer: random stalls and gaps, key prediction.
`timescale 1ns / 100ps

module morton_key_3d_quantize_top_tb
    import mkq_pkg::*;
();

    localparam int AXIS_BITS = 21;
    localparam logic [AXIS_BITS-1:0] AXIS_MAX = '1;   // 2^21 - 1
    localparam int CLK_HALF = 4;                      // 8 ns period
    localparam int RST_CYCLES = 11;
    localparam int SETTLE_CYCLES = 10;                // pipeline is 4 deep, keep some margin
    localparam int RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 166;

    // One particle as it goes onto the input stream.
    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
    } t_particle;

    // One key as it should come out.
    typedef struct {
        logic [KEY_W-1:0] key;
        logic             last;
    } t_key_item;

    // DUT ports; every input is at a known value from time zero.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_CORNER_X;
    logic [COORD_W-1:0]   i_cfg_wdata = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [3*COORD_W-1:0] i_s_tdata = '0;            // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    logic                 i_s_tlast = 1'b0;          // last_in
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [KEY_W:0]       o_m_tdata;                 // morton_key [62:0], zero pad [63]
    logic                 o_m_tlast;                 // last_out

    // Local copy of the domain registers, updated once all four are written.
    logic [COORD_W-1:0] dom_corner [3] = '{default: '0};
    logic [COORD_W-1:0] dom_scale = '0;

    t_particle particle_q [$];      // particles waiting for the driver
    t_key_item expected_key_q [$];  // keys predicted at each input transfer
    int        mismatch_cnt = 0;

    // Idle behavior switches, set per phase by the stimulus process.
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;

    morton_key_3d_quantize_top #(.AXIS_BITS(AXIS_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Key prediction
    // ------------------------------------------------------------------

    // Per-axis code: exact 33-bit offset from the corner, times the Q0.32
    // scale, clamp to [0,1], then scale by 2^21-1 and truncate.
    function automatic logic [AXIS_BITS-1:0] axis_code(logic [COORD_W-1:0] pos,
                                                       logic [COORD_W-1:0] corner);
        logic signed [COORD_W:0] offset;
        logic [63:0]             norm;
        logic [63:0]             scaled;
        offset = $signed({pos[COORD_W-1], pos}) - $signed({corner[COORD_W-1], corner});
        if (offset <= 0) begin
            return '0;                      // at or below the corner
        end
        norm = {31'b0, offset} * {32'b0, dom_scale};
        if (norm[63:32] != 0) begin
            return AXIS_MAX;                // at or past the far edge
        end
        scaled = norm * {{(64-AXIS_BITS){1'b0}}, AXIS_MAX};
        return scaled[32 +: AXIS_BITS];
    endfunction

    // Place axis bit k at key bit 3k.
    function automatic logic [KEY_W-1:0] spread3(logic [AXIS_BITS-1:0] code);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int k = 0; k < AXIS_BITS; k++) begin
            r[3*k] = code[k];
        end
        return r;
    endfunction

    function automatic t_key_item morton_of(t_particle p);
        t_key_item r;
        r.key = spread3(axis_code(p.x, dom_corner[0]))
              | (spread3(axis_code(p.y, dom_corner[1])) << 1)
              | (spread3(axis_code(p.z, dom_corner[2])) << 2);
        r.last = p.last;
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds the input stream from particle_q. The key is predicted
    // at the edge where the transfer happens. Every NBA target is written
    // at most once per edge.
    // ------------------------------------------------------------------
    t_particle held_particle;
    int        send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_key_q.push_back(morton_of(held_particle));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (particle_q.size() != 0) begin
                    held_particle = particle_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {held_particle.z, held_particle.y, held_particle.x};
                    i_s_tlast  <= held_particle.last;
                    send_gap = pick_gap(sender_idles);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure on the output stream, and a field by
    // field check of every key transfer against the oldest prediction.
    // ------------------------------------------------------------------
    int        stall_left = 0;
    t_key_item want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_key_q.size() == 0) begin
                    $display("%0t: key transfer with nothing expected: key %h last %b",
                             $time, o_m_tdata[KEY_W-1:0], o_m_tlast);
                    mismatch_cnt++;
                end else begin
                    want = expected_key_q.pop_front();
                    if (o_m_tdata[KEY_W-1:0] !== want.key) begin
                        $display("%0t: morton_key mismatch: expected %h, actual %h",
                                 $time, want.key, o_m_tdata[KEY_W-1:0]);
                        mismatch_cnt++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $display("%0t: last_out mismatch: expected %b, actual %b",
                                 $time, want.last, o_m_tlast);
                        mismatch_cnt++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                stall_left = pick_gap(receiver_idles);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Registers are only written with the pipeline empty.
    task automatic write_domain(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                logic [COORD_W-1:0] cz, logic [COORD_W-1:0] scale);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [COORD_W-1:0]   val [4];
        idx = '{CFG_CORNER_X, CFG_CORNER_Y, CFG_CORNER_Z, CFG_INV_LEN};
        val = '{cx, cy, cz, scale};
        for (int i = 0; i < 4; i++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx[i];
            i_cfg_wdata <= val[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dom_corner = '{cx, cy, cz};
        dom_scale  = scale;
        @(negedge i_clk);
    endtask

    task automatic add_particle(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [COORD_W-1:0] z, logic last);
        t_particle p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.last = last;
        particle_q.push_back(p);
    endtask

    // Hold the sender until every predicted key has come back, then let
    // the pipeline settle.
    task automatic wait_drained();
        @(negedge i_clk);
        while (particle_q.size() != 0 || i_s_tvalid || expected_key_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // A coordinate near the domain: offsets cover a little below the corner
    // to a little past the far edge (domain length about 2^span_log2).
    function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] corner,
                                                      int span_log2);
        longint     span;
        longint     offset;
        logic [63:0] sum;
        span   = longint'(1) << (span_log2 + 1);
        offset = longint'({$urandom(), $urandom()} % span) - span / 8;
        sum    = longint'($signed(corner)) + offset;
        return sum[COORD_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [COORD_W-1:0] cx, cy, cz, scale;
        int                 span_log2;
        int                 mode;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: registers at reset, scale zero -> every key is zero.
        add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_particle(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        add_particle(32'h1234_5678, 32'h8000_0000, 32'h0000_0000, 1'b0);
        wait_drained();

        // Full scale, corner at origin: one unit lands just under the edge,
        // two units saturate, negatives clamp to zero.
        write_domain(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        add_particle(32'h0000_0001, 32'h0000_0002, 32'h7FFF_FFFF, 1'b0);
        add_particle(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        add_particle(32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 1'b0);
        add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        add_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_particle(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0);
        wait_drained();

        // Corner at the most negative value, smallest nonzero scale: the
        // widest offset stays just inside the domain.
        write_domain(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
        add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        add_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_particle(32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 1'b0);
        wait_drained();

        // Corner at the most positive value: nothing lies above it.
        write_domain(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678);
        add_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_particle(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFE, 1'b1);
        wait_drained();

        // Domain of 4096 units, mixed corners: mid-domain and edge points.
        write_domain(32'hFFFF_FC18, 32'h0, 32'h0000_03E8, 32'h0010_0000);
        add_particle(32'h0000_0000, 32'h0000_0800, 32'h0000_13E8, 1'b0);
        add_particle(32'h0000_0C18, 32'h0000_0FFF, 32'h0000_03E9, 1'b1);
        add_particle(32'hFFFF_FC17, 32'h0000_1000, 32'h0000_0BE8, 1'b0);
        wait_drained();

        // Random phases, each with its own domain and idle pattern. The
        // sender is held in mid-phase until all keys are back.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            span_log2 = $urandom_range(0, 31);
            cx = $urandom();
            cy = $urandom();
            cz = $urandom();
            scale = ({$urandom()} | 32'h8000_0000) >> span_log2;
            if (ph == 0) begin
                cx = '0;
                cy = '0;
                cz = '0;
            end else if (ph == 5) begin
                scale = '0;
            end else if (ph == 6) begin
                scale = $urandom();
            end
            write_domain(cx, cy, cz, scale);

            mode = ph % 4;
            sender_idles   = (mode == 1) || (mode == 3);
            receiver_idles = (mode == 2) || (mode == 3);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 3) != 0) begin
                    add_particle(near_coord(cx, span_log2), near_coord(cy, span_log2),
                                 near_coord(cz, span_log2), $urandom_range(0, 7) == 0);
                end else begin
                    add_particle($urandom(), $urandom(), $urandom(),
                                 1'($urandom_range(0, 1)));
                end
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: morton_key_3d_quantize_top.f
rtl/core/mkq_pkg.sv
rtl/core/mkq_lane.sv
rtl/core/mkq_merge.sv
rtl/core/morton_key_3d_quantize_top.sv
sim/morton_key_3d_quantize_top_tb.sv
